// ===== sv/assert_macros.svh =====
// Assertion macros used by the light pen locator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge, ignored while reset is low
`define LPML_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lpml assertion failed");

// Check a property on every rising edge, reset included
`define LPML_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lpml assertion failed");

`else

`define LPML_ASSERT(lbl, clk, rstn, prop)
`define LPML_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== sv/lpml_pkg.sv =====
// Shared types, constants and probe sequence function of the light pen locator.
package lpml_pkg;

  // Probe codes of the binary search
  localparam logic [7:0] PROBE_FIRST = 8'h0F;
  localparam logic [7:0] PROBE_HIGH  = 8'hF0;
  localparam logic [7:0] PROBE_Q0    = 8'h03;
  localparam logic [7:0] PROBE_Q1    = 8'h0C;
  localparam logic [7:0] PROBE_Q2    = 8'h30;
  localparam logic [7:0] PROBE_Q3    = 8'hC0;

  // Register reset values
  localparam logic [3:0] COL_ATT_RST  = 4'd6;
  localparam logic [3:0] ROW_ATT_RST  = 4'd3;
  localparam logic [3:0] SCAN_BRI_RST = 4'd15;
  localparam logic [3:0] IMG_BRI_RST  = 4'd2;

  localparam logic signed [3:0] POS_NONE = -4'sd1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_COL_ATT  = 2'd0,
    REG_ROW_ATT  = 2'd1,
    REG_SCAN_BRI = 2'd2,
    REG_IMG_BRI  = 2'd3
  } reg_idx_t;

  // Command codes
  localparam logic CMD_LOCATE = 1'b0;

  typedef enum logic [1:0] {
    PR_NEXT,
    PR_FOUND,
    PR_FAIL
  } probe_kind_t;

  typedef struct packed {
    probe_kind_t kind;
    logic [7:0]  code;
    logic [2:0]  pos;
  } probe_res_t;

  // Status of the search after one request
  typedef struct packed {
    logic              search;
    logic              row_phase;
    logic [7:0]        code;
    logic signed [3:0] col;
    logic signed [3:0] row;
  } lpml_status_t;

  // Pixel update towards the image store
  typedef struct packed {
    logic       en;
    logic [2:0] row;
    logic [2:0] col;
    logic       set;
    logic       clr;
  } lpml_wr_t;

  // Next step of the probe sequence
  function automatic probe_res_t next_probe(logic [7:0] code, logic seen);
    probe_res_t res;
    res.kind = PR_NEXT;
    res.code = PROBE_FIRST;
    res.pos  = '0;
    case (code)
      PROBE_FIRST: res.code = seen ? PROBE_Q0 : PROBE_HIGH;
      PROBE_HIGH: begin
        if (seen) res.code = PROBE_Q2;
        else res.kind = PR_FAIL;
      end
      PROBE_Q0: res.code = seen ? 8'h01 : PROBE_Q1;
      PROBE_Q1: begin
        if (seen) res.code = 8'h04;
        else res.kind = PR_FAIL;
      end
      PROBE_Q2: res.code = seen ? 8'h10 : PROBE_Q3;
      PROBE_Q3: begin
        if (seen) res.code = 8'h40;
        else res.kind = PR_FAIL;
      end
      default: begin
        // single-bit codes: found, or step to the odd neighbour, or fail
        for (int b = 0; b < 8; b++) begin
          if (code == (8'h01 << b)) begin
            if (seen) begin
              res.kind = PR_FOUND;
              res.pos  = 3'(b);
            end else if ((b % 2) == 1) begin
              res.kind = PR_FAIL;
            end else begin
              res.code = 8'(8'h01 << (b + 1));
            end
          end
        end
      end
    endcase
    return res;
  endfunction

endpackage

// ===== sv/lpml_step.sv =====
// Search state machine: phase, probe code, attempts and located position.
module lpml_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 command,
  input  logic                 pen_seen,
  input  logic                 draw_set,
  input  logic                 draw_clear,
  input  logic [3:0]           col_att,
  input  logic [3:0]           row_att,
  output lpml_pkg::lpml_status_t status,
  output lpml_pkg::lpml_wr_t     wr
);
  import lpml_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COL,
    PH_ROW
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        code_r, code_nxt;
  logic [3:0]        att_r, att_nxt;
  logic signed [3:0] col_r, col_nxt;
  logic signed [3:0] row_r, row_nxt;
  logic [1:0]        btn_r, btn_nxt;
  logic              finish;
  probe_res_t        pr;

  assign pr = next_probe(code_r, pen_seen);

  // Work out the state after this request
  always_comb begin
    phase_nxt = phase_r;
    code_nxt  = code_r;
    att_nxt   = att_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    btn_nxt   = btn_r;
    finish    = 1'b0;
    if (command == CMD_LOCATE) begin
      phase_nxt = PH_COL;
      code_nxt  = PROBE_FIRST;
      att_nxt   = col_att;
      col_nxt   = POS_NONE;
      row_nxt   = POS_NONE;
      btn_nxt   = {draw_clear, draw_set};
    end else if (phase_r == PH_COL || phase_r == PH_ROW) begin
      case (pr.kind)
        PR_FAIL: begin
          if (att_r > 4'd1) begin
            att_nxt  = att_r - 4'd1;
            code_nxt = PROBE_FIRST;
          end else begin
            finish = 1'b1;
          end
        end
        PR_FOUND: begin
          if (phase_r == PH_COL) begin
            col_nxt   = $signed({1'b0, pr.pos});
            phase_nxt = PH_ROW;
            code_nxt  = PROBE_FIRST;
            att_nxt   = row_att;
          end else begin
            row_nxt = $signed({1'b0, pr.pos});
            finish  = 1'b1;
          end
        end
        default: code_nxt = pr.code;
      endcase
      if (finish) phase_nxt = PH_IDLE;
    end else begin
      phase_nxt = PH_IDLE;
    end
  end

  // Pixel update when the search ends with both coordinates
  always_comb begin
    wr.en  = adv && finish && !col_nxt[3] && !row_nxt[3];
    wr.row = row_nxt[2:0];
    wr.col = col_nxt[2:0];
    wr.set = btn_r[0];
    wr.clr = btn_r[1];
  end

  always_comb begin
    status.search    = (phase_nxt == PH_COL) || (phase_nxt == PH_ROW);
    status.row_phase = (phase_nxt == PH_ROW);
    status.code      = code_nxt;
    status.col       = col_nxt;
    status.row       = row_nxt;
  end

  // Hold state, advance on each request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      code_r  <= '0;
      att_r   <= '0;
      col_r   <= POS_NONE;
      row_r   <= POS_NONE;
      btn_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      att_r   <= att_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      btn_r   <= btn_nxt;
    end
  end

endmodule

// ===== sv/lpml_image.sv =====
// Image store: eight rows of eight pixels, cleared at reset.
module lpml_image (
  input  logic               clk,
  input  logic               rst_n,
  input  lpml_pkg::lpml_wr_t wr,
  output logic [63:0]        img_nxt
);
  import lpml_pkg::*;

  logic [7:0] rows_r [8];
  logic [7:0] rows_nxt [8];
  logic [7:0] bit_mask;

  assign bit_mask = 8'h01 << wr.col;

  // Set, then clear, the addressed pixel
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      rows_nxt[r] = rows_r[r];
      if (wr.en && (wr.row == 3'(r))) begin
        if (wr.set) rows_nxt[r] = rows_nxt[r] | bit_mask;
        if (wr.clr) rows_nxt[r] = rows_nxt[r] & ~bit_mask;
      end
      img_nxt[8*r +: 8] = rows_nxt[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 8; r++) rows_r[r] <= '0;
    end else begin
      for (int r = 0; r < 8; r++) rows_r[r] <= rows_nxt[r];
    end
  end

endmodule

// ===== sv/light_pen_matrix_locator_core.sv =====
// A request passes through the input register, then the result register, before its result is valid.
// Throughput: one request per cycle while results are taken; while a result waits, the
// input register takes one more request and then in_ready stays low until it moves on.
// Reset (rst_n low, synchronous): idle, positions -1, image cleared,
// registers back to 6, 3, 15 and 2.
`include "assert_macros.svh"

module light_pen_matrix_locator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic        in_pen_seen,
  input  logic        in_draw_set,
  input  logic        in_draw_clear,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_frame,
  output logic        out_frame_is_image,
  output logic [3:0]  out_brightness,
  output logic signed [3:0] out_pen_column,
  output logic signed [3:0] out_pen_row,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import lpml_pkg::*;

  logic [3:0]   col_att_r, row_att_r, scan_bri_r, img_bri_r;
  logic         in_valid_r, in_cmd_r, in_seen_r, in_set_r, in_clr_r;
  logic         out_valid_r;
  logic [63:0]  frame_r, frame_nxt;
  logic         is_img_r;
  logic [3:0]   bri_r;
  logic signed [3:0] col_r, row_r;
  logic         adv;
  lpml_status_t status;
  lpml_wr_t     wr;
  logic [63:0]  img_nxt;
  logic [63:0]  probe_frame;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_att_r  <= COL_ATT_RST;
      row_att_r  <= ROW_ATT_RST;
      scan_bri_r <= SCAN_BRI_RST;
      img_bri_r  <= IMG_BRI_RST;
    end else if (cfg_write_en) begin
      case (reg_idx_t'(cfg_index))
        REG_COL_ATT:  col_att_r  <= cfg_wdata;
        REG_ROW_ATT:  row_att_r  <= cfg_wdata;
        REG_SCAN_BRI: scan_bri_r <= cfg_wdata;
        REG_IMG_BRI:  img_bri_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage: hold the request until the step logic takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r  <= in_command;
      in_seen_r <= in_pen_seen;
      in_set_r  <= in_draw_set;
      in_clr_r  <= in_draw_clear;
    end
  end

  lpml_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .command    (in_cmd_r),
    .pen_seen   (in_seen_r),
    .draw_set   (in_set_r),
    .draw_clear (in_clr_r),
    .col_att    (col_att_r),
    .row_att    (row_att_r),
    .status     (status),
    .wr         (wr)
  );

  lpml_image u_image (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .img_nxt (img_nxt)
  );

  // Build the probe frame: column probes repeat the code, row probes light rows
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      probe_frame[8*r +: 8] = status.row_phase ? {8{status.code[r]}} : status.code;
    end
    frame_nxt = status.search ? probe_frame : img_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frame_r  <= frame_nxt;
      is_img_r <= !status.search;
      bri_r    <= status.search ? scan_bri_r : img_bri_r;
      col_r    <= status.col;
      row_r    <= status.row;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame          = frame_r;
  assign out_frame_is_image = is_img_r;
  assign out_brightness     = bri_r;
  assign out_pen_column     = col_r;
  assign out_pen_row        = row_r;

  // A staged request moves on when the result register is free
  `LPML_ASSERT(a_stage_moves, clk, rst_n, in_valid_r && !out_valid_r |=> out_valid_r)
  // A staged request is kept while the result is stalled
  `LPML_ASSERT(a_stage_held, clk, rst_n, in_valid_r && out_valid_r && !out_ready |=> in_valid_r)
  // No row is known while a probe frame is shown
  `LPML_ASSERT(a_probe_no_row, clk, rst_n, out_valid_r && !out_frame_is_image |-> out_pen_row == POS_NONE)

endmodule
